FILE: hw/rtl/mmr_pkg.sv
// Shared types, constants and helpers of the int8 matrix multiply and rescale block.
package mmr_pkg;

   localparam int MAX_DIM     = 8;
   localparam int DIM_W       = 4;
   localparam int IDX_W       = 3;
   localparam int ADDR_W      = 6;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ELEM_W      = 8;
   localparam int SCALE_W     = 24;
   localparam int SPROD_W     = 32;
   localparam int DOT_W       = 20;
   localparam int VALUE_W     = 50;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;

   // Input command codes
   localparam logic [1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COL_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_A     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_B     = 3'd4;

   typedef enum logic [1:0] {
      KIND_LOAD_A,
      KIND_LOAD_B,
      KIND_COMPUTE
   } kind_type;

   // One classified command waiting for the back end
   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   addr;
      logic [ELEM_W-1:0]   value;
   } cmd_type;

   // Effective sizes and rounded scale product
   typedef struct packed {
      logic [DIM_W-1:0]    rows;
      logic [DIM_W-1:0]    inner;
      logic [DIM_W-1:0]    cols;
      logic [SPROD_W-1:0]  sprod;
   } cfg_type;

   // One result element
   typedef struct packed {
      logic [IDX_W-1:0]    row;
      logic [IDX_W-1:0]    col;
      logic [VALUE_W-1:0]  value;
      logic                last;
   } rsp_type;

   // Sizes above the maximum act as the maximum
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
   endfunction

endpackage

FILE: hw/rtl/int8_matrix_multiply_rescale.sv
// Top level: configuration registers, scale product, front and back ends.
// Loads: one transfer per cycle while req_full is low; an element goes through the
// command queue and is written into its store when the idle back end dispatches it.
// Compute: one A and one B element read per cycle, while the result queue has room, by
// the single multiply-accumulate unit, rows*cols*max(inner,1) terms in all.
// Reset: sizes go to 8, scales to 1.0, queues empty; the element stores are not cleared.
module int8_matrix_multiply_rescale import mmr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [1:0]                req_command,
   input  logic [ADDR_W-1:0]         req_elem_addr,
   input  logic signed [ELEM_W-1:0]  req_elem_value,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [IDX_W-1:0]          rsp_out_row,
   output logic [IDX_W-1:0]          rsp_out_col,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic                      rsp_last_flag,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   logic [DIM_W-1:0]     row_count_ff, inner_count_ff, col_count_ff;
   logic [SCALE_W-1:0]   scale_a_ff, scale_b_ff;
   logic [SPROD_W-1:0]   sprod_ff;
   logic [2*SCALE_W-1:0] scale_full;
   cfg_type              cfg;
   logic                 cmd_pop, cmd_empty;
   cmd_type              cmd_head;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= DIM_W'(MAX_DIM);
         inner_count_ff <= DIM_W'(MAX_DIM);
         col_count_ff   <= DIM_W'(MAX_DIM);
         scale_a_ff     <= SCALE_W'(65536);
         scale_b_ff     <= SCALE_W'(65536);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ROW_COUNT:   row_count_ff   <= csr_data[DIM_W-1:0];
            REG_INNER_COUNT: inner_count_ff <= csr_data[DIM_W-1:0];
            REG_COL_COUNT:   col_count_ff   <= csr_data[DIM_W-1:0];
            REG_SCALE_A:     scale_a_ff     <= csr_data[SCALE_W-1:0];
            REG_SCALE_B:     scale_b_ff     <= csr_data[SCALE_W-1:0];
            default:         ;
         endcase
      end
   end

   // Scale product, Q16.16 rounded half up
   assign scale_full = scale_a_ff * scale_b_ff;

   always_ff @(posedge clock) begin
      sprod_ff <= SPROD_W'((scale_full + (2*SCALE_W)'(32768)) >> 16);
   end

   assign cfg = '{rows:  eff_dim(row_count_ff),
                  inner: eff_dim(inner_count_ff),
                  cols:  eff_dim(col_count_ff),
                  sprod: sprod_ff};

   mmr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_command    (req_command),
      .req_elem_addr  (req_elem_addr),
      .req_elem_value (req_elem_value),
      .cfg            (cfg),
      .cmd_pop        (cmd_pop),
      .cmd_empty      (cmd_empty),
      .cmd_head       (cmd_head)
   );

   mmr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd_empty     (cmd_empty),
      .cmd_head      (cmd_head),
      .cmd_pop       (cmd_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last_flag (rsp_last_flag)
   );

endmodule

FILE: hw/rtl/mmr_front.sv
// Front end: accepts items, classifies them and queues the ones that do work.
module mmr_front import mmr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [1:0]               req_command,
   input  logic [ADDR_W-1:0]        req_elem_addr,
   input  logic signed [ELEM_W-1:0] req_elem_value,
   input  cfg_type                  cfg,
   input  logic                     cmd_pop,
   output logic                     cmd_empty,
   output cmd_type                  cmd_head
);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   cmd_type             q_mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   logic [2*DIM_W-1:0]  a_limit;
   logic [2*DIM_W-1:0]  b_limit;
   logic                keep;
   kind_type            kind;
   logic                push_q;

   // Classify the incoming item; out-of-range loads, empty computes and unknown codes are dropped
   always_comb begin
      a_limit = cfg.rows * cfg.inner;
      b_limit = cfg.inner * cfg.cols;
      keep    = 1'b0;
      kind    = KIND_COMPUTE;
      case (req_command)
         CMD_LOAD_A: begin
            kind = KIND_LOAD_A;
            keep = {2'b00, req_elem_addr} < a_limit;
         end
         CMD_LOAD_B: begin
            kind = KIND_LOAD_B;
            keep = {2'b00, req_elem_addr} < b_limit;
         end
         CMD_COMPUTE: begin
            kind = KIND_COMPUTE;
            keep = (cfg.rows != '0) && (cfg.cols != '0);
         end
         default: begin
            kind = KIND_COMPUTE;
            keep = 1'b0;
         end
      endcase
   end

   assign req_full  = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign cmd_empty = (count_ff == '0);
   assign cmd_head  = q_mem_ff[rd_ptr_ff];
   assign push_q    = req_push && !req_full && keep;

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = push_q ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push_q) - (QPTR_W+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_q) begin
         q_mem_ff[wr_ptr_ff] <= '{kind: kind, addr: req_elem_addr,
                                  value: req_elem_value};
      end
   end

endmodule

FILE: hw/rtl/mmr_back.sv
// Back end: element stores, multiply-accumulate sequencer, rescale and result queue.
module mmr_back import mmr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      cmd_empty,
   input  cmd_type                   cmd_head,
   output logic                      cmd_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [IDX_W-1:0]          rsp_out_row,
   output logic [IDX_W-1:0]          rsp_out_col,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic                      rsp_last_flag
);

   localparam int ODEPTH   = 8;
   localparam int OPTR_W   = 3;
   // Results that can be in flight behind the issue point
   localparam int INFLIGHT = 4;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   // Element stores
   logic [ELEM_W-1:0]  a_mem [STORE_DEPTH];
   logic [ELEM_W-1:0]  b_mem [STORE_DEPTH];
   logic [ELEM_W-1:0]  a_rd_ff, b_rd_ff;

   // Sequencer
   state_type          state_ff;
   logic [IDX_W-1:0]   i_ff, j_ff, k_ff;
   logic [ADDR_W-1:0]  a_base_ff, a_idx_ff, b_idx_ff;
   logic               last_k, last_j, last_i, issue;
   logic               start, load_a, load_b;
   logic [ADDR_W:0]    a_next_base;

   // Pipeline stage 1: store data available
   logic               s1_valid_ff, s1_first_ff, s1_lastk_ff, s1_zero_ff, s1_last_ff;
   logic [IDX_W-1:0]   s1_row_ff, s1_col_ff;
   logic signed [2*ELEM_W-1:0] prod;
   logic signed [DOT_W-1:0]    acc_ff, acc_in;

   // Pipeline stage 2: finished dot product
   logic               s2_valid_ff, s2_last_ff;
   logic [IDX_W-1:0]   s2_row_ff, s2_col_ff;
   logic signed [DOT_W-1:0]     s2_dot_ff;
   logic signed [SPROD_W:0]     sprod_s;
   logic signed [DOT_W+SPROD_W:0] mul_full;

   // Pipeline stage 3: scaled result
   logic               s3_valid_ff;
   rsp_type            s3_rsp_ff;

   // Result queue
   rsp_type            o_mem_ff [ODEPTH];
   logic [OPTR_W-1:0]  o_wr_ff, o_rd_ff;
   logic [OPTR_W:0]    o_cnt_ff;
   logic               o_pop;
   rsp_type            o_head;

   // Command dispatch: loads finish at once, a compute starts the sequencer
   always_comb begin
      start  = 1'b0;
      load_a = 1'b0;
      load_b = 1'b0;
      if (state_ff == ST_IDLE && !cmd_empty) begin
         case (cmd_head.kind)
            KIND_LOAD_A:  load_a = 1'b1;
            KIND_LOAD_B:  load_b = 1'b1;
            KIND_COMPUTE: start  = 1'b1;
            default:      start  = 1'b0;
         endcase
      end
   end
   assign cmd_pop = start || load_a || load_b;

   // Loop ends; an inner size of zero gives one zero term per result
   assign last_k = ({1'b0, k_ff} + 1'b1 == cfg.inner) || (cfg.inner == '0);
   assign last_j = ({1'b0, j_ff} + 1'b1 == cfg.cols);
   assign last_i = ({1'b0, i_ff} + 1'b1 == cfg.rows);
   // Issue only while the result queue has room for everything in flight
   assign issue  = (state_ff == ST_RUN) &&
                   (o_cnt_ff <= (OPTR_W+1)'(ODEPTH - INFLIGHT));
   assign a_next_base = {1'b0, a_base_ff} + {3'b000, cfg.inner};

   // Store writes
   always_ff @(posedge clock) begin
      if (load_a) a_mem[cmd_head.addr] <= cmd_head.value;
      if (load_b) b_mem[cmd_head.addr] <= cmd_head.value;
   end

   // Store reads
   always_ff @(posedge clock) begin
      a_rd_ff <= a_mem[a_idx_ff];
      b_rd_ff <= b_mem[b_idx_ff];
   end

   // Sequencer walks rows, columns, then the inner index
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
         i_ff        <= '0;
         j_ff        <= '0;
         k_ff        <= '0;
         a_base_ff   <= '0;
         a_idx_ff    <= '0;
         b_idx_ff    <= '0;
      end else begin
         s1_valid_ff <= issue;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff  <= ST_RUN;
                  i_ff      <= '0;
                  j_ff      <= '0;
                  k_ff      <= '0;
                  a_base_ff <= '0;
                  a_idx_ff  <= '0;
                  b_idx_ff  <= '0;
               end
            end
            ST_RUN: begin
               if (issue) begin
                  if (!last_k) begin
                     k_ff     <= k_ff + 1'b1;
                     a_idx_ff <= a_idx_ff + 1'b1;
                     b_idx_ff <= b_idx_ff + ADDR_W'(cfg.cols);
                  end else begin
                     k_ff <= '0;
                     if (!last_j) begin
                        j_ff     <= j_ff + 1'b1;
                        a_idx_ff <= a_base_ff;
                        b_idx_ff <= ADDR_W'({1'b0, j_ff} + 1'b1);
                     end else begin
                        j_ff     <= '0;
                        b_idx_ff <= '0;
                        if (!last_i) begin
                           i_ff      <= i_ff + 1'b1;
                           a_base_ff <= a_next_base[ADDR_W-1:0];
                           a_idx_ff  <= a_next_base[ADDR_W-1:0];
                        end else begin
                           state_ff <= ST_IDLE;
                        end
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Stage 1 tags travel with the store read
   always_ff @(posedge clock) begin
      s1_first_ff <= (k_ff == '0);
      s1_lastk_ff <= last_k;
      s1_zero_ff  <= (cfg.inner == '0);
      s1_last_ff  <= last_i && last_j;
      s1_row_ff   <= i_ff;
      s1_col_ff   <= j_ff;
   end

   // Multiply-accumulate; the product stays a signed int8 by int8 multiply
   always_comb begin
      prod = '0;
      if (!s1_zero_ff) prod = $signed(a_rd_ff) * $signed(b_rd_ff);
      acc_in = (s1_first_ff ? '0 : acc_ff) +
               {{(DOT_W-2*ELEM_W){prod[2*ELEM_W-1]}}, prod};
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) acc_ff <= acc_in;
      s2_dot_ff <= acc_in;
      s2_row_ff <= s1_row_ff;
      s2_col_ff <= s1_col_ff;
      s2_last_ff <= s1_last_ff;
   end

   // Rescale by the rounded scale product
   assign sprod_s  = {1'b0, cfg.sprod};
   assign mul_full = s2_dot_ff * sprod_s;

   always_ff @(posedge clock) begin
      s3_rsp_ff <= '{row: s2_row_ff, col: s2_col_ff,
                     value: mul_full[VALUE_W-1:0], last: s2_last_ff};
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_lastk_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Result queue
   assign o_pop     = rsp_pop && !rsp_empty;
   assign rsp_empty = (o_cnt_ff == '0);
   assign o_head    = o_mem_ff[o_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         o_wr_ff  <= '0;
         o_rd_ff  <= '0;
         o_cnt_ff <= '0;
      end else begin
         if (s3_valid_ff) o_wr_ff <= o_wr_ff + 1'b1;
         if (o_pop)       o_rd_ff <= o_rd_ff + 1'b1;
         o_cnt_ff <= o_cnt_ff + (OPTR_W+1)'(s3_valid_ff) - (OPTR_W+1)'(o_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff) o_mem_ff[o_wr_ff] <= s3_rsp_ff;
   end

   assign rsp_out_row   = o_head.row;
   assign rsp_out_col   = o_head.col;
   assign rsp_out_value = o_head.value;
   assign rsp_last_flag = o_head.last;

endmodule
